FILE: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Table size, opcode and status codes, item and record layouts.
// ----------------------------------------------------------------------------
package skt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_LIST   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_NONE    = 3'd3,
    ST_REMOVED = 3'd4
  } status_t;

  // request item
  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] key;
    logic [7:0]         age;
  } in_item_t;

  // result item
  typedef struct packed {
    status_t            status;
    logic signed [31:0] found_key;
    logic [7:0]         found_age;
    logic               last;
  } out_item_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic               removed;
    logic [7:0]         age;
    logic signed [31:0] key;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

FILE: rtl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int  DATA_W = 8,
  parameter int  DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl: table sequencer
// Binary search over the sorted RAM, insert by shifting entries up one
// slot (read and write pipelined), soft delete by read-modify-write of the
// removed mark, and a list walk that holds back one record to flag the last.
// ----------------------------------------------------------------------------
module skt_ctrl import skt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // request side
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  // result side
  output logic             emit_valid,
  input  logic             emit_ready,
  output out_item_t        emit_item,
  // table RAM
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output rec_t             ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  rec_t             ram_rdata
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SRCH     = 9'b000000010,
    S_SRCH_W   = 9'b000000100,
    S_HIT_W    = 9'b000001000,
    S_DECIDE   = 9'b000010000,
    S_SHIFT    = 9'b000100000,
    S_EMIT     = 9'b001000000,
    S_LIST     = 9'b010000000,
    S_LIST_END = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  opcode_t            op_r, op_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [7:0]         age_r, age_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic               hit_r, hit_nxt;
  rec_t               rec_r, rec_nxt;
  out_item_t          res_r, res_nxt;
  logic [CNT_W-1:0]   sh_i_r, sh_i_nxt;
  logic               sh_v_r, sh_v_nxt;
  logic [IDX_W-1:0]   sh_wa_r, sh_wa_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   cur_a_r, cur_a_nxt;
  logic               dv_r, dv_nxt;
  rec_t               pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid_full;
  logic [CNT_W-1:0]   sh_prev;
  logic               list_act;
  logic               list_stall;

  // search midpoint and shift source
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_full   = mid_sum[CNT_W:1];
  assign sh_prev    = sh_i_r - 1'b1;
  // list walk: current read data is an active record
  assign list_act   = dv_r && !ram_rdata.removed;
  assign list_stall = list_act && pend_v_r && !emit_ready;

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    age_nxt    = age_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    hit_nxt    = hit_r;
    rec_nxt    = rec_r;
    res_nxt    = res_r;
    sh_i_nxt   = sh_i_r;
    sh_v_nxt   = sh_v_r;
    sh_wa_nxt  = sh_wa_r;
    idx_nxt    = idx_r;
    cur_a_nxt  = cur_a_r;
    dv_nxt     = dv_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    in_ready   = 1'b0;
    emit_valid = 1'b0;
    emit_item  = res_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_item.opcode;
          key_nxt = in_item.key;
          age_nxt = in_item.age;
          if (in_item.opcode == OP_LIST) begin
            idx_nxt    = '0;
            dv_nxt     = 1'b0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_LIST;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = cnt_r;
            state_nxt = S_SRCH;
          end
        end
      end

      // lower-bound search: probe mid, or the final position
      S_SRCH: begin
        if (lo_r < hi_r) begin
          ram_raddr = mid_full[IDX_W-1:0];
          state_nxt = S_SRCH_W;
        end else if (lo_r < cnt_r) begin
          ram_raddr = lo_r[IDX_W-1:0];
          state_nxt = S_HIT_W;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = S_DECIDE;
        end
      end

      S_SRCH_W: begin
        if (ram_rdata.key < key_r) begin
          lo_nxt = mid_full + 1'b1;
        end else begin
          hi_nxt = mid_full;
        end
        state_nxt = S_SRCH;
      end

      S_HIT_W: begin
        hit_nxt   = (ram_rdata.key == key_r);
        rec_nxt   = ram_rdata;
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        state_nxt      = S_EMIT;
        res_nxt.last   = 1'b1;
        res_nxt.status = ST_OK;
        case (op_r)
          OP_INSERT: begin
            if (hit_r) begin
              res_nxt.status    = ST_DUP;
              res_nxt.found_key = rec_r.key;
              res_nxt.found_age = rec_r.age;
            end else if (cnt_r >= CNT_W'(TABLE_DEPTH)) begin
              res_nxt.status    = ST_FULL;
              res_nxt.found_key = '0;
              res_nxt.found_age = '0;
            end else begin
              sh_i_nxt  = cnt_r;
              sh_v_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
          end
          OP_REMOVE, OP_QUERY: begin
            if (!hit_r) begin
              res_nxt.status    = ST_NONE;
              res_nxt.found_key = '0;
              res_nxt.found_age = '0;
            end else begin
              res_nxt.found_key = rec_r.key;
              res_nxt.found_age = rec_r.age;
              if (rec_r.removed) begin
                res_nxt.status = ST_REMOVED;
              end else if (op_r == OP_REMOVE) begin
                // set the removed mark in place
                ram_we            = 1'b1;
                ram_waddr         = lo_r[IDX_W-1:0];
                ram_wdata         = rec_r;
                ram_wdata.removed = 1'b1;
              end
            end
          end
          default: begin
            res_nxt.status    = ST_NONE;
            res_nxt.found_key = '0;
            res_nxt.found_age = '0;
          end
        endcase
      end

      // move entries [pos, n) up one, top first; read i-1, write it to i
      S_SHIFT: begin
        if (sh_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wa_r;
          ram_wdata = ram_rdata;
        end
        if (sh_i_r > lo_r) begin
          ram_raddr = sh_prev[IDX_W-1:0];
          sh_wa_nxt = sh_i_r[IDX_W-1:0];
          sh_v_nxt  = 1'b1;
          sh_i_nxt  = sh_prev;
        end else begin
          sh_v_nxt = 1'b0;
          if (!sh_v_r) begin
            ram_we            = 1'b1;
            ram_waddr         = lo_r[IDX_W-1:0];
            ram_wdata.removed = 1'b0;
            ram_wdata.age     = age_r;
            ram_wdata.key     = key_r;
            cnt_nxt           = cnt_r + 1'b1;
            res_nxt.status    = ST_OK;
            res_nxt.found_key = key_r;
            res_nxt.found_age = age_r;
            res_nxt.last      = 1'b1;
            state_nxt         = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        emit_valid = 1'b1;
        emit_item  = res_r;
        if (emit_ready) begin
          state_nxt = S_IDLE;
        end
      end

      // walk all entries; the held record goes out once a later one shows up
      S_LIST: begin
        emit_valid          = list_act && pend_v_r;
        emit_item.status    = ST_OK;
        emit_item.found_key = pend_r.key;
        emit_item.found_age = pend_r.age;
        emit_item.last      = 1'b0;
        if (list_stall) begin
          ram_raddr = cur_a_r;
        end else begin
          if (list_act) begin
            pend_nxt   = ram_rdata;
            pend_v_nxt = 1'b1;
          end
          if (idx_r < cnt_r) begin
            ram_raddr = idx_r[IDX_W-1:0];
            cur_a_nxt = idx_r[IDX_W-1:0];
            idx_nxt   = idx_r + 1'b1;
            dv_nxt    = 1'b1;
          end else begin
            dv_nxt = 1'b0;
            if (!dv_r) begin
              state_nxt = S_LIST_END;
            end
          end
        end
      end

      S_LIST_END: begin
        emit_valid     = 1'b1;
        emit_item.last = 1'b1;
        if (pend_v_r) begin
          emit_item.status    = ST_OK;
          emit_item.found_key = pend_r.key;
          emit_item.found_age = pend_r.age;
        end else begin
          emit_item.status    = ST_NONE;
          emit_item.found_key = '0;
          emit_item.found_age = '0;
        end
        if (emit_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      sh_v_r   <= 1'b0;
      dv_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      sh_v_r   <= sh_v_nxt;
      dv_r     <= dv_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    age_r   <= age_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    hit_r   <= hit_nxt;
    rec_r   <= rec_nxt;
    res_r   <= res_nxt;
    sh_i_r  <= sh_i_nxt;
    sh_wa_r <= sh_wa_nxt;
    idx_r   <= idx_nxt;
    cur_a_r <= cur_a_nxt;
    pend_r  <= pend_nxt;
  end

`ifndef SYNTH
  // entry count never passes the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // the count only ever grows by one (insert)
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(cnt_r)) |-> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("entry count changed by other than one");

  // search window stays inside the filled part of the table
  a_srch_win: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (lo_r <= hi_r && hi_r <= cnt_r))
    else $error("search window out of range");

  // writes land at or below the current fill
  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(ram_waddr) <= cnt_r))
    else $error("table write above fill level");
`endif

endmodule

FILE: rtl/sorted_key_table_with_soft_delete.sv
// ----------------------------------------------------------------------------
// sorted_key_table_with_soft_delete: sorted record table with soft delete
// Query and remove run a binary search of up to 7 steps; insert also shifts
// each entry above the slot up by one (up to 63 entries); list walks every
// stored entry, stalled by the result side.
// One item in flight at a time; the single table RAM port pair sets the pace.
// Reset (rst_n, synchronous) empties the table; RAM contents are left as is.
// ----------------------------------------------------------------------------
module sorted_key_table_with_soft_delete import skt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic             emit_valid;
  logic             emit_ready;
  out_item_t        emit_item;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata_bits;
  rec_t             ram_rdata;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;

  assign ram_rdata = rec_t'(ram_rdata_bits);

  // table storage: key, age and removed mark in one word
  skt_ram #(
    .DATA_W (REC_W),
    .DEPTH  (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_bits)
  );

  skt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_item  (emit_item),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // output register: refills in the cycle the held item is taken
  assign emit_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_valid && emit_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_item_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: verif/skt_table_checker.sv
// ----------------------------------------------------------------------------
// skt_table_checker: result checker for the sorted key table
// Watches both channels. Each accepted request updates a private copy of the
// sorted table and queues the result items it should cause. Each accepted
// result item is then compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module skt_table_checker import skt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        due_count,
  output int        checked_count,
  output int        table_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  // private copy of the table, kept in ascending signed key order
  logic signed [31:0] row_key     [TABLE_DEPTH];
  logic [7:0]         row_age     [TABLE_DEPTH];
  logic               row_removed [TABLE_DEPTH];
  int                 rows;

  out_item_t due_results[$];

  function automatic out_item_t make_result(status_t st, logic signed [31:0] k,
                                            logic [7:0] a, logic fin);
    out_item_t r;
    r.status    = st;
    r.found_key = k;
    r.found_age = a;
    r.last      = fin;
    return r;
  endfunction

  // first row whose key is not below k
  function automatic int find_slot(logic signed [31:0] k);
    int pos;
    pos = 0;
    while (pos < rows && row_key[pos] < k) pos++;
    return pos;
  endfunction

  // update the table copy and queue the result items of one request
  task automatic apply_request(in_item_t req);
    int  pos;
    int  active;
    int  listed;
    bit  hit;
    if (req.opcode == OP_LIST) begin
      active = 0;
      for (int i = 0; i < rows; i++) if (!row_removed[i]) active++;
      if (active == 0) begin
        due_results.push_back(make_result(ST_NONE, '0, '0, 1'b1));
      end else begin
        listed = 0;
        for (int i = 0; i < rows; i++) begin
          if (!row_removed[i]) begin
            listed++;
            due_results.push_back(make_result(ST_OK, row_key[i], row_age[i],
                                              listed == active));
          end
        end
      end
      return;
    end

    pos = find_slot(req.key);
    hit = (pos < rows) && (row_key[pos] == req.key);

    if (req.opcode == OP_INSERT) begin
      // duplicate check wins over the full check; removed keys still count
      if (hit) begin
        due_results.push_back(make_result(ST_DUP, row_key[pos], row_age[pos], 1'b1));
      end else if (rows >= TABLE_DEPTH) begin
        due_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
      end else begin
        for (int i = rows; i > pos; i--) begin
          row_key[i]     = row_key[i-1];
          row_age[i]     = row_age[i-1];
          row_removed[i] = row_removed[i-1];
        end
        row_key[pos]     = req.key;
        row_age[pos]     = req.age;
        row_removed[pos] = 1'b0;
        rows++;
        due_results.push_back(make_result(ST_OK, req.key, req.age, 1'b1));
      end
    end else if (!hit) begin
      due_results.push_back(make_result(ST_NONE, '0, '0, 1'b1));
    end else if (row_removed[pos]) begin
      due_results.push_back(make_result(ST_REMOVED, row_key[pos], row_age[pos], 1'b1));
    end else begin
      if (req.opcode == OP_REMOVE) row_removed[pos] = 1'b1;
      due_results.push_back(make_result(ST_OK, row_key[pos], row_age[pos], 1'b1));
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      $error("result item with none expected: status %0d key %0d age %0d last %0d",
             got.status, got.found_key, got.found_age, got.last);
      mismatch_count++;
      return;
    end
    want = due_results.pop_front();
    checked_count++;
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.found_key !== want.found_key) begin
      $error("found_key: expected %0d, got %0d", want.found_key, got.found_key);
      mismatch_count++;
    end
    if (got.found_age !== want.found_age) begin
      $error("found_age: expected %0d, got %0d", want.found_age, got.found_age);
      mismatch_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatch_count++;
    end
  endtask

  // channel monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rows = 0;
      due_results.delete();
    end else begin
      if (in_valid && in_ready) apply_request(in_item);
      if (out_valid && out_ready) check_result(out_item);
    end
    due_count  = due_results.size();
    table_fill = rows;
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for sorted_key_table_with_soft_delete
// Directed requests for empty, removed, duplicate and extreme keys, then
// random insert/remove/query/list traffic that fills the table past capacity,
// under changing idle mixes on both channels and one long result-side stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  localparam int N_RANDOM       = 330;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic      clk;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;
  int op_sent [4] = '{default: 0};
  int sent_total  = 0;

  logic signed [31:0] known_keys[$];

  int mismatch_count;
  int due_count;
  int checked_count;
  int table_fill;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sorted_key_table_with_soft_delete u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  skt_table_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .due_count      (due_count),
    .checked_count  (checked_count),
    .table_fill     (table_fill)
  );

  // watchdog: ends the run after a long stretch with no item moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one request and hold it until accepted
  task automatic send_request(opcode_t op, logic signed [31:0] k, logic [7:0] a);
    in_item_t req;
    req.opcode = op;
    req.key    = k;
    req.age    = a;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
    op_sent[op]++;
    sent_total++;
    if (op == OP_INSERT) known_keys.push_back(k);
  endtask

  // stop offering, wait for every pending result, then let the block settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // keys already used at the given rate, some extremes, the rest fresh random keys
  function automatic logic signed [31:0] pick_key(int reuse_pct);
    if (known_keys.size() != 0 && $urandom_range(99) < reuse_pct)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(5))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return KEY_MIN + 1;
        3:       return KEY_MAX - 1;
        4:       return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_request;
    int roll;
    roll = $urandom_range(99);
    if (roll < 45)      send_request(OP_INSERT, pick_key(25), 8'($urandom_range(255)));
    else if (roll < 65) send_request(OP_REMOVE, pick_key(80), 8'($urandom_range(255)));
    else if (roll < 90) send_request(OP_QUERY,  pick_key(75), 8'($urandom_range(255)));
    else                send_request(OP_LIST,   $urandom,     8'($urandom_range(255)));
  endtask

  // stimulus and verdict
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 31;
    rx_idle_pct = 84;

    // empty table, then a table holding only removed records
    send_request(OP_LIST,   32'sd0, 8'd0);
    send_request(OP_QUERY,  32'sd7, 8'd0);
    send_request(OP_REMOVE, 32'sd7, 8'd0);
    send_request(OP_INSERT, 32'sd7, 8'h5A);
    send_request(OP_REMOVE, 32'sd7, 8'h00);
    send_request(OP_LIST,   32'sd7, 8'hFF);
    send_request(OP_INSERT, 32'sd7, 8'hA5);
    send_request(OP_QUERY,  32'sd7, 8'h00);
    send_request(OP_REMOVE, 32'sd7, 8'h00);
    // extreme keys and payloads, duplicate of an active key
    send_request(OP_INSERT, KEY_MAX, 8'hFF);
    send_request(OP_INSERT, KEY_MIN, 8'h00);
    send_request(OP_INSERT, 32'sd0,  8'h81);
    send_request(OP_INSERT, -32'sd1, 8'h7E);
    send_request(OP_INSERT, 32'sd0,  8'h11);
    send_request(OP_QUERY,  KEY_MIN, 8'h00);
    send_request(OP_QUERY,  KEY_MAX, 8'h00);
    send_request(OP_REMOVE, -32'sd1, 8'h00);
    send_request(OP_QUERY,  -32'sd1, 8'h00);
    send_request(OP_QUERY,  32'sd5,  8'h00);
    send_request(OP_REMOVE, 32'sd5,  8'h00);
    send_request(OP_LIST,   KEY_MIN, 8'h00);
    drain();

    // random traffic, sender lightly idle, receiver mostly stalled
    repeat (110) random_request();
    drain();

    // long result-side hold-off while requests keep coming
    tx_idle_pct = 0;
    rx_hold_req = 1'b1;
    repeat (6) random_request();
    drain();

    // roles swapped
    tx_idle_pct = 84;
    rx_idle_pct = 31;
    repeat (110) random_request();
    drain();

    // back to back on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (N_RANDOM - 226) random_request();
    drain();

    $display("Run: %0d requests (%0d insert, %0d remove, %0d query, %0d list), %0d results",
             sent_total, op_sent[OP_INSERT], op_sent[OP_REMOVE], op_sent[OP_QUERY],
             op_sent[OP_LIST], checked_count);
    $display("Table ended with %0d of %0d rows; %0d mismatches, %0d results outstanding",
             table_fill, TABLE_DEPTH, mismatch_count, due_count);

    if (mismatch_count == 0 && due_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
